>>> src/sfr_pkg.sv
// sfr_pkg: shared types, constants and helpers for the stream find/replace block.
// No dependencies; imported by every module under src/.
package sfr_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int REPLACE_BYTES     = 8;
  localparam int RES_MAX           = 8;              // results one request can cause
  localparam int OUT_CELLS         = RES_MAX + 1;    // one left over plus a full request
  localparam int WC_W              = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int OC_W              = $clog2(OUT_CELLS + 1);
  localparam int ADDR_W            = 6;

  typedef enum logic [2:0] {
    REG_FIND_PATTERN    = 3'd0,
    REG_FIND_LENGTH     = 3'd1,
    REG_REPLACE_TEXT    = 3'd2,
    REG_REPLACE_LENGTH  = 3'd3,
    REG_OUTPUT_CAPACITY = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] find_pattern;
    logic [3:0]  find_length;
    logic [63:0] replace_text;
    logic [3:0]  replace_length;
    logic [15:0] output_capacity;
    logic        flen_wr;        // find_length written at this edge
    logic [3:0]  flen_new;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic shift;
  } win_ctl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } out_ctl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    logic       trunc;
  } res_t;

  function automatic logic [WC_W-1:0] eff_find_len(input logic [3:0] raw);
    logic [WC_W-1:0] k;
    if (raw == 4'd0) begin
      k = WC_W'(1);
    end else if (int'(raw) > MAX_PATTERN_BYTES) begin
      k = WC_W'(MAX_PATTERN_BYTES);
    end else begin
      k = WC_W'(raw);
    end
    return k;
  endfunction

  function automatic logic [3:0] eff_rep_len(input logic [3:0] raw);
    return (int'(raw) > REPLACE_BYTES) ? 4'(REPLACE_BYTES) : raw;
  endfunction

endpackage

>>> src/stream_find_replace.sv
// stream_find_replace: top level, window cell row, match/emit control, result chain.
// Depends on sfr_pkg, sfr_cfg_regs, sfr_win_cell, sfr_out_cell.
//
//  channel | ports                                        | moves
//  in      | in_valid, in_stall, in_byte, in_end_of_string | one string byte per request
//  out     | out_valid, out_stall, out_byte, out_byte_valid,| one result per request
//          | out_last_result, out_truncated                |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata,  | 64-bit registers at 8*index
//          | pready                                        |
//
// An input request is processed in the cycle it is accepted; its results are registered
// into the result chain behind any result still queued. Input is taken whenever
// at most one result is still queued, so single-result bytes stream at one per cycle
// while out_stall is low; more results hold the input until at most one is queued.
// in_stall comes from a register only. Reset is synchronous; no clearing pass.
module stream_find_replace (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_of_string,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_last_result,
  output logic                       out_truncated,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import sfr_pkg::*;

  cfg_t cfg;

  logic [WC_W-1:0] wc_r, wc_nxt;
  logic [15:0]     emit_cnt_r, emit_cnt_nxt;
  logic            drop_r, drop_nxt;
  logic [OC_W-1:0] cnt_r, cnt_nxt;

  logic            acc, pop;
  logic [WC_W-1:0] k_eff, n_eff;
  logic            full, hit, eos;
  logic [3:0]      r_eff, m, emit_n, nout;
  logic [15:0]     lim, avail;
  logic            drop_now, bare;
  logic [OC_W-1:0] base;

  logic [7:0]      wcur  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] wmatch;
  logic [MAX_PATTERN_BYTES-1:0] take_in;
  win_ctl_t        wctl;
  res_t            ent_list [RES_MAX];
  res_t            chain    [OUT_CELLS];

  sfr_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign eos   = in_end_of_string;
  assign acc   = in_valid & ~in_stall;
  assign pop   = out_valid & ~out_stall;
  assign k_eff = eff_find_len(cfg.find_length);
  assign r_eff = eff_rep_len(cfg.replace_length);
  assign n_eff = (wc_r >= k_eff) ? '0 : wc_r;
  assign full  = ((n_eff + WC_W'(1)) == k_eff);

  // window row
  assign wctl.load  = acc;
  assign wctl.shift = full & ~hit;

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_win
    logic [7:0] nbr;
    if (i + 1 < MAX_PATTERN_BYTES) begin : g_n
      assign nbr = wcur[i+1];
    end else begin : g_e
      assign nbr = 8'd0;
    end
    assign take_in[i] = (n_eff == WC_W'(i));
    sfr_win_cell u_cell (
      .clk, .ctl(wctl), .take_in(take_in[i]), .in_byte, .nbr_byte(nbr),
      .pat_byte(cfg.find_pattern[8*i +: 8]), .cur_byte(wcur[i]), .match(wmatch[i])
    );
  end

  always_comb begin
    hit = full;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (WC_W'(i) < k_eff && !wmatch[i]) begin
        hit = 1'b0;
      end
    end
  end

  // result count and capacity limit
  always_comb begin
    priority if (hit) begin
      m = r_eff;
    end else if (eos) begin
      m = 4'(n_eff) + 4'd1;
    end else if (full) begin
      m = 4'd1;
    end else begin
      m = 4'd0;
    end
  end

  assign lim      = (cfg.output_capacity == 16'd0) ? 16'd0 : cfg.output_capacity - 16'd1;
  assign avail    = (emit_cnt_r < lim) ? lim - emit_cnt_r : 16'd0;
  assign drop_now = ({12'd0, m} > avail);
  assign emit_n   = drop_now ? avail[3:0] : m;
  assign bare     = eos && (emit_n == 4'd0);
  assign nout     = bare ? 4'd1 : emit_n;

  for (genvar j = 0; j < RES_MAX; j++) begin : g_list
    logic [7:0] wb;
    if (j < MAX_PATTERN_BYTES) begin : g_w
      assign wb = wcur[j];
    end else begin : g_z
      assign wb = 8'd0;
    end
    always_comb begin
      ent_list[j].data       = hit ? cfg.replace_text[8*j +: 8] : wb;
      ent_list[j].byte_valid = 1'b1;
      ent_list[j].last       = eos && (4'(j) == nout - 4'd1);
      ent_list[j].trunc      = drop_r | drop_now;
      if (bare) begin
        ent_list[j].data       = 8'd0;
        ent_list[j].byte_valid = 1'b0;
      end
    end
  end

  // result chain: new entries land right behind whatever is left after the pop
  assign base = cnt_r - OC_W'(pop);

  for (genvar i = 0; i < OUT_CELLS; i++) begin : g_out
    res_t     lo_ent, hi_ent, nbr, new_ent;
    out_ctl_t octl;
    if (i < RES_MAX) begin : g_lo
      assign lo_ent = ent_list[i];
    end else begin : g_lz
      assign lo_ent = '0;
    end
    if (i >= 1) begin : g_hi
      assign hi_ent = ent_list[i-1];
    end else begin : g_hz
      assign hi_ent = '0;
    end
    if (i + 1 < OUT_CELLS) begin : g_nb
      assign nbr = chain[i+1];
    end else begin : g_nz
      assign nbr = '0;
    end
    assign new_ent    = (base == '0) ? lo_ent : hi_ent;
    assign octl.shift = pop;
    assign octl.load  = acc && (((base == '0) && (4'(i) < nout)) ||
                                ((base == OC_W'(1)) && (i >= 1) && (4'(i) <= nout)));
    sfr_out_cell u_cell (
      .clk, .ctl(octl), .nbr_ent(nbr), .new_ent(new_ent), .ent(chain[i])
    );
  end

  assign out_valid       = (cnt_r != '0);
  assign out_byte        = chain[0].data;
  assign out_byte_valid  = chain[0].byte_valid;
  assign out_last_result = chain[0].last;
  assign out_truncated   = chain[0].trunc;
  assign in_stall        = (cnt_r > OC_W'(1));

  always_comb begin
    wc_nxt       = wc_r;
    emit_cnt_nxt = emit_cnt_r;
    drop_nxt     = drop_r;
    cnt_nxt      = cnt_r - OC_W'(pop);
    if (cfg.flen_wr && (wc_r >= eff_find_len(cfg.flen_new))) begin
      wc_nxt = '0;
    end
    if (acc) begin
      cnt_nxt = cnt_nxt + OC_W'(nout);
      priority if (hit || eos) begin
        wc_nxt = '0;
      end else if (full) begin
        wc_nxt = k_eff - WC_W'(1);
      end else begin
        wc_nxt = n_eff + WC_W'(1);
      end
      emit_cnt_nxt = eos ? 16'd0 : emit_cnt_r + {12'd0, emit_n};
      drop_nxt     = eos ? 1'b0  : (drop_r | drop_now);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r       <= '0;
      emit_cnt_r <= '0;
      drop_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      wc_r       <= wc_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      drop_r     <= drop_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OC_W'(OUT_CELLS))
    else $error("result chain overfilled");

  a_window_below_k: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r < k_eff)
    else $error("window holds a full pattern between requests");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && eos |=> (emit_cnt_r == 16'd0) && !drop_r && (wc_r == '0))
    else $error("string state not cleared after end of string");

  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last_result)
    else $error("bare result not marked last");

endmodule

>>> src/sfr_cfg_regs.sv
// sfr_cfg_regs: APB-style register file for pattern, replacement and capacity.
// Depends on sfr_pkg.
module sfr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output sfr_pkg::cfg_t              cfg
);
  import sfr_pkg::*;

  logic [63:0] find_pattern_r;
  logic [3:0]  find_length_r;
  logic [63:0] replace_text_r;
  logic [3:0]  replace_length_r;
  logic [15:0] output_capacity_r;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      find_pattern_r    <= '0;
      find_length_r     <= 4'd1;
      replace_text_r    <= '0;
      replace_length_r  <= '0;
      output_capacity_r <= 16'hFFFF;
    end else if (wr) begin
      unique case (idx)
        REG_FIND_PATTERN:    find_pattern_r    <= pwdata;
        REG_FIND_LENGTH:     find_length_r     <= pwdata[3:0];
        REG_REPLACE_TEXT:    replace_text_r    <= pwdata;
        REG_REPLACE_LENGTH:  replace_length_r  <= pwdata[3:0];
        REG_OUTPUT_CAPACITY: output_capacity_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIND_PATTERN:    prdata = find_pattern_r;
      REG_FIND_LENGTH:     prdata = {60'd0, find_length_r};
      REG_REPLACE_TEXT:    prdata = replace_text_r;
      REG_REPLACE_LENGTH:  prdata = {60'd0, replace_length_r};
      REG_OUTPUT_CAPACITY: prdata = {48'd0, output_capacity_r};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    cfg.find_pattern    = find_pattern_r;
    cfg.find_length     = find_length_r;
    cfg.replace_text    = replace_text_r;
    cfg.replace_length  = replace_length_r;
    cfg.output_capacity = output_capacity_r;
    cfg.flen_wr         = wr && (idx == REG_FIND_LENGTH);
    cfg.flen_new        = pwdata[3:0];
  end

endmodule

>>> src/sfr_win_cell.sv
// sfr_win_cell: one byte of the match window with its pattern comparator.
// Depends on sfr_pkg. Shifts toward cell 0 when the oldest byte leaves.
module sfr_win_cell (
  input  logic              clk,
  input  sfr_pkg::win_ctl_t ctl,
  input  logic              take_in,   // new byte lands in this cell
  input  logic [7:0]        in_byte,
  input  logic [7:0]        nbr_byte,  // current byte of the next-newer cell
  input  logic [7:0]        pat_byte,
  output logic [7:0]        cur_byte,
  output logic              match
);
  import sfr_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign cur_byte = take_in ? in_byte : byte_r;
  assign match    = (cur_byte == pat_byte);
  assign byte_nxt = ctl.shift ? nbr_byte : cur_byte;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      byte_r <= byte_nxt;
    end
  end

endmodule

>>> src/sfr_out_cell.sv
// sfr_out_cell: one slot of the result shift chain; cell 0 drives the output.
// Depends on sfr_pkg.
module sfr_out_cell (
  input  logic              clk,
  input  sfr_pkg::out_ctl_t ctl,
  input  sfr_pkg::res_t     nbr_ent,
  input  sfr_pkg::res_t     new_ent,
  output sfr_pkg::res_t     ent
);
  import sfr_pkg::*;

  res_t ent_r;
  res_t ent_nxt;

  always_comb begin
    priority if (ctl.load) begin
      ent_nxt = new_ent;
    end else if (ctl.shift) begin
      ent_nxt = nbr_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule
